// File: hdl/pnpd_pkg.sv
// ----------------------------------------------------------------------------
// pnpd_pkg
// Shared widths, register indexes and control types for the nearest pair
// distance block.
// ----------------------------------------------------------------------------
package pnpd_pkg;

  // Squared distances are unsigned Q41.0, distances unsigned Q21.0
  localparam int SQ_BITS        = 41;
  localparam int DIST_BITS      = 21;
  localparam int VALUE_BITS_DEF = 16;
  localparam int CFG_ADDR_BITS  = 1;

  typedef logic [SQ_BITS-1:0] sq_t;

  localparam sq_t SQ_MAX            = '1;
  localparam sq_t DEFAULT_BOUND_RST = sq_t'(1) << 40;

  // Configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DEFAULT_BOUND = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_STOP_DIST     = 1'b1;

  // Markers carried with each word
  typedef struct packed {
    logic last_attr;
    logic last_pair;
    logic first_item;
  } pnpd_flags_t;

  // Sequencer strobes into the accumulator
  typedef struct packed {
    logic load;    // capture a new word
    logic square;  // square the difference, apply start marker
    logic update;  // add, prune, tighten bound
  } pnpd_ctrl_t;

  // Comparison state seen by the sequencer
  typedef struct packed {
    logic found;
    logic stopped;
    sq_t  best_sum;
  } pnpd_status_t;

endpackage

// File: hdl/pnpd_isqrt.sv
// ----------------------------------------------------------------------------
// pnpd_isqrt
// Floor square root of a squared distance, one result bit per cycle with a
// single shared subtract and compare.
// ----------------------------------------------------------------------------
module pnpd_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  pnpd_pkg::sq_t                  x_in,
  output logic                           busy,
  output logic [pnpd_pkg::DIST_BITS-1:0] root
);
  import pnpd_pkg::*;

  localparam int W = SQ_BITS + 1;

  logic         busy_r, busy_nxt;
  sq_t          rem_r, rem_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic [W-1:0] bit_r, bit_nxt;
  logic [W-1:0] trial;
  logic         take;

  // One restoring step
  assign trial = res_r + bit_r;
  assign take  = {1'b0, rem_r} >= trial;

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = x_in;
      res_nxt  = '0;
      bit_nxt  = W'(1) << (SQ_BITS - 1);
    end else if (busy_r) begin
      if (take) begin
        rem_nxt = rem_r - trial[SQ_BITS-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[DIST_BITS-1:0];

endmodule

// File: hdl/pnpd_accum.sv
// ----------------------------------------------------------------------------
// pnpd_accum
// Squared difference, running sum with pruning, bound tracking and early
// stop for one attribute word at a time.
// ----------------------------------------------------------------------------
module pnpd_accum #(
  parameter int VALUE_BITS = pnpd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pnpd_pkg::pnpd_ctrl_t          ctrl,
  input  logic signed [VALUE_BITS-1:0]  value_a,
  input  logic signed [VALUE_BITS-1:0]  value_b,
  input  pnpd_pkg::pnpd_flags_t         flags,
  input  pnpd_pkg::sq_t                 bound_sq,
  input  pnpd_pkg::sq_t                 default_bound_sq,
  input  pnpd_pkg::sq_t                 stop_distance_sq,
  output pnpd_pkg::pnpd_status_t        status
);
  import pnpd_pkg::*;

  localparam int DW   = VALUE_BITS + 1;
  localparam int MAGW = (DW > 22) ? DW : 22;
  localparam logic [MAGW-1:0] SAT_LIM = MAGW'(1) << 21;

  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;
  logic [MAGW-1:0]      mag_ext;
  logic [41:0]          prod;
  logic [SQ_BITS:0]     sum_w;
  sq_t                  sum_sat;

  logic [20:0]  mag_r;
  logic         sat_r;
  pnpd_flags_t  flags_r;
  sq_t          bound_in_r;
  sq_t          sq_r, sq_nxt;

  sq_t  run_r, run_nxt;
  sq_t  bound_r, bound_nxt;
  sq_t  best_r, best_nxt;
  logic found_r, found_nxt;
  logic pruned_r, pruned_nxt;
  logic stopped_r, stopped_nxt;

  // Absolute difference, saturated to the square range
  assign diff    = DW'(value_a) - DW'(value_b);
  assign mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign mag_ext = MAGW'(mag);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_r      <= mag_ext[20:0];
      sat_r      <= mag_ext >= SAT_LIM;
      flags_r    <= flags;
      bound_in_r <= bound_sq;
    end
    if (ctrl.square) begin
      sq_r <= sq_nxt;
    end
  end

  // Square, clamped to 41 bits
  assign prod = 42'(mag_r) * 42'(mag_r);

  always_comb begin
    if (sat_r || (prod > 42'(SQ_MAX))) begin
      sq_nxt = SQ_MAX;
    end else begin
      sq_nxt = prod[SQ_BITS-1:0];
    end
  end

  // Saturating add of the new square
  assign sum_w   = {1'b0, run_r} + {1'b0, sq_r};
  assign sum_sat = sum_w[SQ_BITS] ? SQ_MAX : sum_w[SQ_BITS-1:0];

  // Prune, close the object pair, tighten bound, early stop
  always_comb begin
    run_nxt     = run_r;
    bound_nxt   = bound_r;
    best_nxt    = best_r;
    found_nxt   = found_r;
    pruned_nxt  = pruned_r;
    stopped_nxt = stopped_r;
    if (!stopped_r) begin
      if (!pruned_r) begin
        run_nxt = sum_sat;
        if (sum_sat > bound_r) begin
          pruned_nxt = 1'b1;
        end
      end
      if (flags_r.last_attr) begin
        if (!pruned_nxt) begin
          found_nxt = 1'b1;
          best_nxt  = run_nxt;
          bound_nxt = run_nxt;
          if (run_nxt < stop_distance_sq) begin
            stopped_nxt = 1'b1;
          end
        end
        run_nxt    = '0;
        pruned_nxt = 1'b0;
      end
    end
    if (flags_r.last_attr && flags_r.last_pair) begin
      run_nxt    = '0;
      pruned_nxt = 1'b0;
    end
  end

  // Comparison state; start marker clears it before the word is summed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= '0;
      bound_r   <= DEFAULT_BOUND_RST;
      best_r    <= '0;
      found_r   <= 1'b0;
      pruned_r  <= 1'b0;
      stopped_r <= 1'b0;
    end else begin
      priority if (ctrl.square && flags_r.first_item) begin
        run_r     <= '0;
        bound_r   <= (bound_in_r != '0) ? bound_in_r : default_bound_sq;
        best_r    <= '0;
        found_r   <= 1'b0;
        pruned_r  <= 1'b0;
        stopped_r <= 1'b0;
      end else if (ctrl.update) begin
        run_r     <= run_nxt;
        bound_r   <= bound_nxt;
        best_r    <= best_nxt;
        found_r   <= found_nxt;
        pruned_r  <= pruned_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  assign status.found    = found_r;
  assign status.stopped  = stopped_r;
  assign status.best_sum = best_r;

endmodule

// File: hdl/pruned_nearest_pair_distance.sv
// ----------------------------------------------------------------------------
// pruned_nearest_pair_distance
// Single-linkage distance between two clusters with pruning of object pairs
// against the running bound and an early stop on a close enough pair.
// ----------------------------------------------------------------------------
// Each attribute word goes through capture and absolute difference, the
// square in the multiplier, then the saturating add with the bound
// compare. The word that closes a comparison (last attribute of the last
// pair) then passes a launch step and the bit-serial square root unit,
// one root bit a cycle, and the result is loaded into the output
// register. The input is not ready while a word is in flight; a finished
// result waits in the output register and does not block the next word,
// unless a second result is ready before the first has been taken.
module pruned_nearest_pair_distance #(
  parameter int VALUE_BITS = pnpd_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [pnpd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  pnpd_pkg::sq_t                      cfg_wdata,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [VALUE_BITS-1:0]       in_value_a,
  input  logic signed [VALUE_BITS-1:0]       in_value_b,
  input  logic                               in_last_attr,
  input  logic                               in_last_pair,
  input  logic                               in_first_item,
  input  pnpd_pkg::sq_t                      in_bound_sq,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic                               out_early_stop,
  output logic [pnpd_pkg::DIST_BITS-1:0]     out_best_distance,
  output pnpd_pkg::sq_t                      out_best_distance_sq
);
  import pnpd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_LAUNCH = 5'b01000,
    ST_ROOT   = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  logic         end_r;
  sq_t          default_bound_r;
  sq_t          stop_dist_r;
  pnpd_ctrl_t   ctrl;
  pnpd_flags_t  flags;
  pnpd_status_t status;
  logic         accept;
  logic         sqrt_busy;
  logic [DIST_BITS-1:0] root;
  sq_t          root_x;
  logic         out_load;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r;
  logic                 out_early_r;
  logic [DIST_BITS-1:0] out_dist_r;
  sq_t                  out_dist_sq_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_bound_r <= DEFAULT_BOUND_RST;
      stop_dist_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEFAULT_BOUND: default_bound_r <= cfg_wdata;
        CFG_STOP_DIST:     stop_dist_r     <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign flags.last_attr  = in_last_attr;
  assign flags.last_pair  = in_last_pair;
  assign flags.first_item = in_first_item;

  assign ctrl.load   = accept;
  assign ctrl.square = (state_r == ST_SQUARE);
  assign ctrl.update = (state_r == ST_UPDATE);

  assign root_x   = status.found ? status.best_sum : '0;
  assign out_load = (state_r == ST_ROOT) && !sqrt_busy && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = end_r ? ST_LAUNCH : ST_IDLE;
      ST_LAUNCH: state_nxt = ST_ROOT;
      ST_ROOT:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      end_r <= in_last_attr && in_last_pair;
    end
  end

  pnpd_accum #(
    .VALUE_BITS (VALUE_BITS)
  ) u_accum (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .value_a          (in_value_a),
    .value_b          (in_value_b),
    .flags            (flags),
    .bound_sq         (in_bound_sq),
    .default_bound_sq (default_bound_r),
    .stop_distance_sq (stop_dist_r),
    .status           (status)
  );

  pnpd_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_LAUNCH),
    .x_in  (root_x),
    .busy  (sqrt_busy),
    .root  (root)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r   <= status.found;
      out_early_r   <= status.found && status.stopped;
      out_dist_r    <= root;
      out_dist_sq_r <= root_x;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_early_stop       = out_early_r;
  assign out_best_distance    = out_dist_r;
  assign out_best_distance_sq = out_dist_sq_r;

  // Checks
  a_accept_square: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SQUARE)
    else $error("accepted word did not move to the square step");

  a_root_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LAUNCH |=> sqrt_busy)
    else $error("square root unit not started");

  a_stop_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_early_stop |-> out_found)
    else $error("early stop without a found pair");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_best_distance_sq == '0) && (out_best_distance == '0))
    else $error("non-zero distance with nothing found");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pruned nearest pair distance block. Attribute
// words are streamed in as object pairs grouped into cluster comparisons. A
// tracker follows every accepted word with its own model of the bound,
// pruning and early stop, and queues the result each closing word should
// give. Result words are checked field by field in order. Directed
// comparisons come first, then four phases of random comparisons with
// different register settings and idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pnpd_pkg::*;

  localparam int VB          = VALUE_BITS_DEF;
  localparam int QUIET_LIMIT = 4000;  // cycles with no word moving at all
  localparam int DRAIN_WAIT  = 40;    // lets the square root of a closing word finish

  typedef struct {
    logic signed [VB-1:0] value_a;
    logic signed [VB-1:0] value_b;
    logic                 last_attr;
    logic                 last_pair;
    logic                 first_item;
    sq_t                  bound_sq;
  } attr_word_t;

  typedef struct {
    logic                 found;
    logic                 early_stop;
    logic [DIST_BITS-1:0] distance;
    sq_t                  distance_sq;
  } linkage_result_t;

  // Follows the comparison state and holds the results still to come
  class linkage_tracker;
    sq_t             default_bound;
    sq_t             stop_level;
    sq_t             run_sum;
    sq_t             bound;
    sq_t             best_sum;
    bit              found;
    bit              pruned;
    bit              stopped;
    linkage_result_t awaited[$];
    int              mismatches;

    function new();
      default_bound = DEFAULT_BOUND_RST;
      stop_level    = '0;
      run_sum       = '0;
      bound         = DEFAULT_BOUND_RST;
      best_sum      = '0;
      found         = 1'b0;
      pruned        = 1'b0;
      stopped       = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_registers(sq_t new_default, sq_t new_stop);
      default_bound = new_default;
      stop_level    = new_stop;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Squared attribute difference, saturated to the squared width
    static function sq_t gap_squared(logic signed [VB-1:0] a, logic signed [VB-1:0] b);
      longint          diff;
      longint unsigned mag;
      longint unsigned prod;
      diff = longint'(a) - longint'(b);
      mag  = (diff < 0) ? -diff : diff;
      if (mag >= (64'd1 << 21)) return SQ_MAX;
      prod = mag * mag;
      return (prod > 64'(SQ_MAX)) ? SQ_MAX : sq_t'(prod);
    endfunction

    // Floor square root, one root bit at a time from the top
    static function logic [DIST_BITS-1:0] root_floor(sq_t x);
      logic [DIST_BITS-1:0] root;
      logic [DIST_BITS-1:0] trial;
      longint unsigned      trial_sq;
      root = '0;
      for (int i = DIST_BITS - 1; i >= 0; i--) begin
        trial    = root | (DIST_BITS'(1) << i);
        trial_sq = 64'(trial) * 64'(trial);
        if (trial_sq <= 64'(x)) root = trial;
      end
      return root;
    endfunction

    // Apply one accepted word; a closing word queues its result
    function void track_word(attr_word_t w);
      logic [SQ_BITS:0] total;
      linkage_result_t  r;
      if (w.first_item) begin
        bound    = (w.bound_sq != '0) ? w.bound_sq : default_bound;
        run_sum  = '0;
        best_sum = '0;
        found    = 1'b0;
        pruned   = 1'b0;
        stopped  = 1'b0;
      end
      if (!stopped) begin
        if (!pruned) begin
          total   = {1'b0, run_sum} + {1'b0, gap_squared(w.value_a, w.value_b)};
          run_sum = total[SQ_BITS] ? SQ_MAX : total[SQ_BITS-1:0];
          if (run_sum > bound) pruned = 1'b1;
        end
        if (w.last_attr) begin
          // surviving pair (ties included) tightens the bound
          if (!pruned) begin
            found    = 1'b1;
            best_sum = run_sum;
            bound    = run_sum;
            if (run_sum < stop_level) stopped = 1'b1;
          end
          run_sum = '0;
          pruned  = 1'b0;
        end
      end
      if (w.last_attr && w.last_pair) begin
        r.found       = found;
        r.early_stop  = found && stopped;
        r.distance_sq = found ? best_sum : '0;
        r.distance    = root_floor(r.distance_sq);
        awaited.push_back(r);
        run_sum = '0;
        pruned  = 1'b0;
      end
    endfunction

    task flag_mismatch(string what);
      $display("tb: mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(linkage_result_t got);
      linkage_result_t want;
      if (awaited.size() == 0) begin
        flag_mismatch("result word with nothing awaited");
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found)
        flag_mismatch($sformatf("found %0b, wanted %0b", got.found, want.found));
      if (got.early_stop !== want.early_stop)
        flag_mismatch($sformatf("early_stop %0b, wanted %0b", got.early_stop,
                                want.early_stop));
      if (got.distance !== want.distance)
        flag_mismatch($sformatf("best_distance %0d, wanted %0d", got.distance,
                                want.distance));
      if (got.distance_sq !== want.distance_sq)
        flag_mismatch($sformatf("best_distance_sq %0d, wanted %0d", got.distance_sq,
                                want.distance_sq));
    endtask
  endclass

  // Block ports
  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_we        = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr      = '0;
  sq_t                      cfg_wdata     = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic signed [VB-1:0]     in_value_a    = '0;
  logic signed [VB-1:0]     in_value_b    = '0;
  logic                     in_last_attr  = 1'b0;
  logic                     in_last_pair  = 1'b0;
  logic                     in_first_item = 1'b0;
  sq_t                      in_bound_sq   = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic                     out_found;
  logic                     out_early_stop;
  logic [DIST_BITS-1:0]     out_best_distance;
  sq_t                      out_best_distance_sq;

  linkage_tracker book;
  int             send_idle    = 0;  // percent of cycles the sender holds back
  int             recv_stall   = 0;  // percent of cycles the receiver stalls
  int             words_sent   = 0;
  int             quiet_cycles = 0;

  pruned_nearest_pair_distance u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_value_a           (in_value_a),
    .in_value_b           (in_value_b),
    .in_last_attr         (in_last_attr),
    .in_last_pair         (in_last_pair),
    .in_first_item        (in_first_item),
    .in_bound_sq          (in_bound_sq),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_found            (out_found),
    .out_early_stop       (out_early_stop),
    .out_best_distance    (out_best_distance),
    .out_best_distance_sq (out_best_distance_sq)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // Result monitor
  always @(posedge clk) begin
    linkage_result_t seen;
    if (out_valid && out_ready) begin
      seen.found       = out_found;
      seen.early_stop  = out_early_stop;
      seen.distance    = out_best_distance;
      seen.distance_sq = out_best_distance_sq;
      book.check_result(seen);
    end
  end

  // Watchdog: ends a run that has stopped moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic sq_t pick_bound();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return '0;
    if (r < 7) return sq_t'($urandom_range(0, 1 << 20));
    if (r < 9) return sq_t'({8'($urandom_range(0, 255)), 32'($urandom)});
    return DEFAULT_BOUND_RST;
  endfunction

  function automatic logic signed [VB-1:0] edge_value();
    case ($urandom_range(0, 3))
      0:       return {1'b1, {(VB-1){1'b0}}};
      1:       return {1'b0, {(VB-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Present one word; valid stays up until it is taken
  task automatic send_word(attr_word_t w);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value_a    <= w.value_a;
    in_value_b    <= w.value_b;
    in_last_attr  <= w.last_attr;
    in_last_pair  <= w.last_pair;
    in_first_item <= w.first_item;
    in_bound_sq   <= w.bound_sq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.track_word(w);
    words_sent++;
  endtask

  task automatic put(logic signed [VB-1:0] a, logic signed [VB-1:0] b, logic la,
                     logic lp, logic fi, sq_t bnd);
    attr_word_t w;
    w.value_a    = a;
    w.value_b    = b;
    w.last_attr  = la;
    w.last_pair  = lp;
    w.first_item = fi;
    w.bound_sq   = bnd;
    send_word(w);
  endtask

  // Both registers, written back to back while the block is idle
  task automatic set_registers(sq_t new_default, sq_t new_stop);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DEFAULT_BOUND;
    cfg_wdata <= new_default;
    @(posedge clk);
    cfg_addr  <= CFG_STOP_DIST;
    cfg_wdata <= new_stop;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.set_registers(new_default, new_stop);
  endtask

  // Wait for every awaited result, then let any word still in flight finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // A few arbitrary words: stray markers, restarts, odd bounds
  task automatic send_noise();
    attr_word_t w;
    int         n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      w.value_a    = VB'($urandom);
      w.value_b    = VB'($urandom);
      w.last_attr  = 1'($urandom_range(0, 1));
      w.last_pair  = 1'($urandom_range(0, 1));
      w.first_item = 1'($urandom_range(0, 1));
      w.bound_sq   = pick_bound();
      send_word(w);
    end
  endtask

  // One cluster comparison; now and then without start marker or cut short
  task automatic send_comparison(int long_attrs);
    attr_word_t           w;
    logic signed [VB-1:0] ca[$];
    logic signed [VB-1:0] cb[$];
    logic signed [VB-1:0] va;
    int                   n_pairs;
    int                   n_attrs;
    int                   spread;
    int                   cut_at;
    int                   mode;
    bit                   skip_start;
    bit                   cut_short;
    sq_t                  start_bound;
    if (long_attrs > 0) begin
      n_attrs = long_attrs;
      n_pairs = 1;
    end else begin
      n_attrs = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 4);
      n_pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
    end
    skip_start  = ($urandom_range(0, 99) < 3);
    cut_short   = ($urandom_range(0, 99) < 5);
    cut_at      = $urandom_range(0, n_pairs - 1);
    start_bound = pick_bound();
    spread      = 1 << $urandom_range(0, 9);
    for (int p = 0; p < n_pairs; p++) begin
      // a repeated pair gives a sum equal to the bound it set
      if (p == 0 || $urandom_range(0, 99) >= 15) begin
        ca.delete();
        cb.delete();
        for (int k = 0; k < n_attrs; k++) begin
          mode = $urandom_range(0, 9);
          if (mode == 0) begin
            ca.push_back(edge_value());
            cb.push_back(edge_value());
          end else if (mode < 3) begin
            ca.push_back(VB'($urandom));
            cb.push_back(VB'($urandom));
          end else begin
            va = VB'($urandom);
            ca.push_back(va);
            cb.push_back(VB'(int'(va) + $urandom_range(0, 2 * spread) - spread));
          end
        end
      end
      for (int k = 0; k < n_attrs; k++) begin
        if (cut_short && p == cut_at && k == n_attrs - 1) return;
        w.value_a    = ca[k];
        w.value_b    = cb[k];
        w.last_attr  = (k == n_attrs - 1);
        w.last_pair  = w.last_attr ? (p == n_pairs - 1) : ($urandom_range(0, 9) == 0);
        w.first_item = (p == 0 && k == 0 && !skip_start);
        w.bound_sq   = w.first_item ? start_bound : pick_bound();
        send_word(w);
      end
    end
  endtask

  // Main sequence
  initial begin
    int target;
    book = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_registers(DEFAULT_BOUND_RST, '0);
    // comparison with no start marker, on the reset bound
    put(32767, -32768, 1, 1, 0, '0);
    // default bound, a tie, a stray last_pair and a pruned pair
    put(100, 90, 0, 0, 1, '0);
    put(-5, 5, 1, 0, 0, '0);
    put(100, 90, 0, 1, 0, '0);
    put(-5, 5, 1, 0, 0, '0);
    put(1000, 0, 0, 0, 0, '0);
    put(0, 0, 1, 1, 0, '0);
    // nothing within the bound
    put(0, 2, 1, 1, 1, sq_t'(1));
    // abandoned comparison, then a fresh one at the reset default bound
    put(3, 0, 1, 0, 1, '0);
    put(0, 0, 1, 0, 1, DEFAULT_BOUND_RST);
    put(1, 1, 1, 1, 0, '0);
    settle();

    set_registers('0, DEFAULT_BOUND_RST);
    // zero bound: exact match stops, later words are ignored
    put(5, 5, 0, 0, 1, '0);
    put(-1, -1, 1, 0, 0, '0);
    put(7, 0, 1, 0, 0, '0);
    put(-32768, 32767, 0, 1, 0, '0);
    put(9, 9, 1, 1, 0, '0);
    put(1, 0, 1, 1, 1, '0);
    // widest difference still below the stop level
    put(-32768, 32767, 1, 0, 1, DEFAULT_BOUND_RST);
    put(0, 0, 1, 1, 0, '0);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
          set_registers(DEFAULT_BOUND_RST, sq_t'($urandom_range(0, 1 << 17)));
          send_comparison(256);
        end
        1: begin
          send_idle  = 76;
          recv_stall = 0;
          set_registers(sq_t'({8'($urandom_range(0, 255)), 32'($urandom)}), '0);
        end
        2: begin
          send_idle  = 0;
          recv_stall = 76;
          set_registers('0, sq_t'($urandom_range(0, 1 << 16)));
          send_comparison($urandom_range(64, 256));
        end
        default: begin
          send_idle  = 8;
          recv_stall = 8;
          set_registers(sq_t'($urandom_range(1 << 10, 1 << 24)),
                        sq_t'($urandom_range(0, 1 << 16)));
        end
      endcase
      target = words_sent + 270;
      while (words_sent < target) begin
        if ($urandom_range(0, 99) < 10) send_noise();
        send_comparison(0);
      end
      settle();
    end

    if (book.mismatches == 0 && book.outstanding() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

// File: pruned_nearest_pair_distance.f
hdl/pnpd_pkg.sv
hdl/pnpd_isqrt.sv
hdl/pnpd_accum.sv
hdl/pruned_nearest_pair_distance.sv
tb/tb.sv
